### design/svpc_pkg.sv
package svpc_pkg;

    localparam int unsigned DATA_W         = 16;
    localparam int unsigned SECTOR_W       = 3;
    localparam int unsigned CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DC_BUS_VOLTAGE = 1'd1;

    localparam logic [DATA_W-1:0] PERIOD_RESET = 16'd8500;
    localparam logic [DATA_W-1:0] DC_BUS_RESET = 16'd6144;

    localparam int unsigned MAG_W          = 34;
    localparam int unsigned PROJ_W         = MAG_W + 1;
    localparam int unsigned DEN_W          = 35;
    localparam int unsigned Q_W            = DATA_W;
    localparam int unsigned NUM_W          = MAG_W + DATA_W;
    localparam int unsigned BITS_PER_STAGE = 2;
    localparam int unsigned DIV_STAGES     = Q_W / BITS_PER_STAGE;
    localparam int unsigned DC_SHIFT       = 17;
    localparam int unsigned ALPHA_SHIFT    = 16;

    localparam logic signed [MAG_W-1:0] SQRT3_Q16 = 34'sd113512;

    localparam logic [SECTOR_W-1:0] SEC_ZERO = 3'd0;
    localparam logic [SECTOR_W-1:0] SEC_1    = 3'd1;
    localparam logic [SECTOR_W-1:0] SEC_2    = 3'd2;
    localparam logic [SECTOR_W-1:0] SEC_3    = 3'd3;
    localparam logic [SECTOR_W-1:0] SEC_4    = 3'd4;
    localparam logic [SECTOR_W-1:0] SEC_5    = 3'd5;
    localparam logic [SECTOR_W-1:0] SEC_6    = 3'd6;
    localparam logic [SECTOR_W-1:0] SEC_BAD  = 3'd7;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic                overmodulated;
    } side_t;

endpackage

### design/svpc_if.sv
interface svpc_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [svpc_pkg::DATA_W-1:0] v_alpha;
    logic signed [svpc_pkg::DATA_W-1:0] v_beta;

    modport source (output valid, v_alpha, v_beta, input ready);
    modport sink (input valid, v_alpha, v_beta, output ready);
endinterface

interface svpc_out_if;
    logic                          valid;
    logic                          ready;
    logic [svpc_pkg::DATA_W-1:0]   cmp_a;
    logic [svpc_pkg::DATA_W-1:0]   cmp_b;
    logic [svpc_pkg::DATA_W-1:0]   cmp_c;
    logic [svpc_pkg::SECTOR_W-1:0] sector;
    logic                          overmodulated;

    modport source (output valid, cmp_a, cmp_b, cmp_c, sector, overmodulated, input ready);
    modport sink (input valid, cmp_a, cmp_b, cmp_c, sector, overmodulated, output ready);
endinterface

### design/space_vector_pwm_compare.sv
// Seven-segment space vector PWM compare generator.
// Requests on the voltage channel carry a signed Q8.8 (alpha, beta) vector; each
// one yields exactly one request on the compare channel with the three phase
// compare values in timer ticks, the sector code and the overmodulation flag.
// The period and dc-bus registers are written through the plain write port
// and must only change while no request is in flight.
// The block is a fourteen-stage pipeline: four stages for the projections,
// sector choice, products and divisor choice, eight stages of a restoring
// divider that retires two quotient bits per stage for both active times in
// parallel, and two stages for the phase times and their assignment.
// One request can be accepted in every cycle as long as no stall at the
// compare channel holds the pipeline.
// Each stage holds its item until the next stage is free, so a stall at the
// compare channel fills the empty stages first and then holds ready low; no
// request is lost or repeated.
// Reset empties the pipeline and restores the period to 8500 ticks and the
// dc-bus voltage to 6144 (24 V in Q8.8).
module space_vector_pwm_compare (
    input  logic                              clk,
    input  logic                              rst_n,
    svpc_in_if.sink                           voltage,
    svpc_out_if.source                        compare,
    input  logic                              wr_en,
    input  logic [svpc_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [svpc_pkg::DATA_W-1:0]       wr_data
);

    localparam int unsigned DW  = svpc_pkg::DATA_W;
    localparam int unsigned MW  = svpc_pkg::MAG_W;
    localparam int unsigned PW  = svpc_pkg::PROJ_W;
    localparam int unsigned NW  = svpc_pkg::NUM_W;
    localparam int unsigned EW  = svpc_pkg::DEN_W;
    localparam int unsigned SW  = svpc_pkg::SECTOR_W;

    function automatic logic [DW-1:0] clamp_ts(input logic [DW:0] v, input logic [DW-1:0] ts);
        return (v > {1'b0, ts}) ? ts : v[DW-1:0];
    endfunction

    logic [DW-1:0] period_reg;
    logic [DW-1:0] dc_bus_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= svpc_pkg::PERIOD_RESET;
            dc_bus_reg <= svpc_pkg::DC_BUS_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                svpc_pkg::REG_PERIOD_TICKS:   period_reg <= wr_data;
                svpc_pkg::REG_DC_BUS_VOLTAGE: dc_bus_reg <= wr_data;
            endcase
        end
    end

    logic go1, go2, go3, go4, go5, go6;
    logic div_in_ready, div_out_valid;

    logic                 v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    logic signed [MW-1:0] sbe1_reg, sbe1_next;
    logic signed [MW-1:0] a3_1_reg, a3_1_next;
    logic signed [MW-1:0] al_x, be_x;

    logic signed [PW-1:0] sbe_x, a3_x, nx, ny, nz, ms, ns;
    logic [SW-1:0]        sec_raw;
    logic [MW-1:0]        m2_reg, m2_next, n2_reg, n2_next;
    logic [SW-1:0]        sec2_reg, sec2_next;

    logic [NW-1:0]        pm3_reg, pm3_next, pn3_reg, pn3_next;
    logic [EW-1:0]        sum3_reg, sum3_next;
    logic [SW-1:0]        sec3_reg;

    logic [EW-1:0]        d_x;
    logic                 ovm4_next;
    logic [NW-1:0]        pm4_reg, pn4_reg;
    logic [EW-1:0]        den4_reg, den4_next;
    svpc_pkg::side_t      side4_reg;

    logic [DW-1:0]        tm, tn;
    svpc_pkg::side_t      div_side;

    logic [DW-1:0]        diff;
    logic [DW-1:0]        ta5_reg, ta5_next;
    logic [DW:0]          tb5_reg, tb5_next, tc5_reg, tc5_next;
    svpc_pkg::side_t      side5_reg;

    logic [DW-1:0]        ca_next, cb_next, cc_next;
    logic [DW-1:0]        ca6_reg, cb6_reg, cc6_reg;
    svpc_pkg::side_t      side6_reg;

    assign go6 = !v6_reg || compare.ready;
    assign go5 = !v5_reg || go6;
    assign go4 = !v4_reg || div_in_ready;
    assign go3 = !v3_reg || go4;
    assign go2 = !v2_reg || go3;
    assign go1 = !v1_reg || go2;

    assign voltage.ready = go1;

    always_comb
    begin
        al_x      = {{(MW - DW){voltage.v_alpha[DW-1]}}, voltage.v_alpha};
        be_x      = {{(MW - DW){voltage.v_beta[DW-1]}}, voltage.v_beta};
        sbe1_next = be_x * svpc_pkg::SQRT3_Q16;
        a3_1_next = (al_x <<< (svpc_pkg::ALPHA_SHIFT + 1)) + (al_x <<< svpc_pkg::ALPHA_SHIFT);
    end

    always_comb
    begin
        sbe_x     = {sbe1_reg[MW-1], sbe1_reg};
        a3_x      = {a3_1_reg[MW-1], a3_1_reg};
        nx        = sbe_x <<< 1;
        ny        = a3_x + sbe_x;
        nz        = sbe_x - a3_x;
        sec_raw   = {ny[PW-1], nz[PW-1], (!nx[PW-1]) && (nx != '0)};
        ms        = '0;
        ns        = '0;
        sec2_next = sec_raw;
        unique case (sec_raw)
            svpc_pkg::SEC_1:
            begin
                ms = nz;
                ns = ny;
            end
            svpc_pkg::SEC_2:
            begin
                ms = ny;
                ns = -nx;
            end
            svpc_pkg::SEC_3:
            begin
                ms = -nz;
                ns = nx;
            end
            svpc_pkg::SEC_4:
            begin
                ms = -nx;
                ns = nz;
            end
            svpc_pkg::SEC_5:
            begin
                ms = nx;
                ns = -ny;
            end
            svpc_pkg::SEC_6:
            begin
                ms = -ny;
                ns = -nz;
            end
            default:
            begin
                sec2_next = svpc_pkg::SEC_ZERO;
            end
        endcase
        m2_next = ms[PW-1] ? '0 : ms[MW-1:0];
        n2_next = ns[PW-1] ? '0 : ns[MW-1:0];
    end

    always_comb
    begin
        pm3_next  = {{DW{1'b0}}, m2_reg} * {{MW{1'b0}}, period_reg};
        pn3_next  = {{DW{1'b0}}, n2_reg} * {{MW{1'b0}}, period_reg};
        sum3_next = {{(EW - MW){1'b0}}, m2_reg} + {{(EW - MW){1'b0}}, n2_reg};
    end

    always_comb
    begin
        d_x       = {{(EW - DW - svpc_pkg::DC_SHIFT){1'b0}}, dc_bus_reg,
                     {svpc_pkg::DC_SHIFT{1'b0}}};
        ovm4_next = sum3_reg > d_x;
        if (sum3_reg == '0)
        begin
            den4_next = EW'(1);
        end
        else
        begin
            den4_next = ovm4_next ? sum3_reg : d_x;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (go1)
            begin
                v1_reg <= voltage.valid;
            end
            if (go2)
            begin
                v2_reg <= v1_reg;
            end
            if (go3)
            begin
                v3_reg <= v2_reg;
            end
            if (go4)
            begin
                v4_reg <= v3_reg;
            end
            if (go5)
            begin
                v5_reg <= div_out_valid;
            end
            if (go6)
            begin
                v6_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go1 && voltage.valid)
        begin
            sbe1_reg <= sbe1_next;
            a3_1_reg <= a3_1_next;
        end
        if (go2 && v1_reg)
        begin
            m2_reg   <= m2_next;
            n2_reg   <= n2_next;
            sec2_reg <= sec2_next;
        end
        if (go3 && v2_reg)
        begin
            pm3_reg  <= pm3_next;
            pn3_reg  <= pn3_next;
            sum3_reg <= sum3_next;
            sec3_reg <= sec2_reg;
        end
        if (go4 && v3_reg)
        begin
            pm4_reg                 <= pm3_reg;
            pn4_reg                 <= pn3_reg;
            den4_reg                <= den4_next;
            side4_reg.sector        <= sec3_reg;
            side4_reg.overmodulated <= ovm4_next;
        end
        if (go5 && div_out_valid)
        begin
            ta5_reg   <= ta5_next;
            tb5_reg   <= tb5_next;
            tc5_reg   <= tc5_next;
            side5_reg <= div_side;
        end
        if (go6 && v5_reg)
        begin
            ca6_reg   <= ca_next;
            cb6_reg   <= cb_next;
            cc6_reg   <= cc_next;
            side6_reg <= side5_reg;
        end
    end

    svpc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .in_ready  (div_in_ready),
        .num_m     (pm4_reg),
        .num_n     (pn4_reg),
        .den       (den4_reg),
        .side_in   (side4_reg),
        .out_valid (div_out_valid),
        .out_ready (go5),
        .quo_m     (tm),
        .quo_n     (tn),
        .side_out  (div_side)
    );

    always_comb
    begin
        diff     = period_reg - tm - tn;
        ta5_next = {2'b00, diff[DW-1:2]};
        tb5_next = {1'b0, ta5_next} + {2'b00, tm[DW-1:1]};
        tc5_next = tb5_next + {2'b00, tn[DW-1:1]};
    end

    always_comb
    begin
        unique case (side5_reg.sector)
            svpc_pkg::SEC_1:
            begin
                ca_next = clamp_ts(tb5_reg, period_reg);
                cb_next = clamp_ts({1'b0, ta5_reg}, period_reg);
                cc_next = clamp_ts(tc5_reg, period_reg);
            end
            svpc_pkg::SEC_2:
            begin
                ca_next = clamp_ts({1'b0, ta5_reg}, period_reg);
                cb_next = clamp_ts(tc5_reg, period_reg);
                cc_next = clamp_ts(tb5_reg, period_reg);
            end
            svpc_pkg::SEC_3:
            begin
                ca_next = clamp_ts({1'b0, ta5_reg}, period_reg);
                cb_next = clamp_ts(tb5_reg, period_reg);
                cc_next = clamp_ts(tc5_reg, period_reg);
            end
            svpc_pkg::SEC_4:
            begin
                ca_next = clamp_ts(tc5_reg, period_reg);
                cb_next = clamp_ts(tb5_reg, period_reg);
                cc_next = clamp_ts({1'b0, ta5_reg}, period_reg);
            end
            svpc_pkg::SEC_5:
            begin
                ca_next = clamp_ts(tc5_reg, period_reg);
                cb_next = clamp_ts({1'b0, ta5_reg}, period_reg);
                cc_next = clamp_ts(tb5_reg, period_reg);
            end
            svpc_pkg::SEC_6:
            begin
                ca_next = clamp_ts(tb5_reg, period_reg);
                cb_next = clamp_ts(tc5_reg, period_reg);
                cc_next = clamp_ts({1'b0, ta5_reg}, period_reg);
            end
            default:
            begin
                ca_next = clamp_ts({1'b0, ta5_reg}, period_reg);
                cb_next = clamp_ts({1'b0, ta5_reg}, period_reg);
                cc_next = clamp_ts({1'b0, ta5_reg}, period_reg);
            end
        endcase
    end

    assign compare.valid         = v6_reg;
    assign compare.cmp_a         = ca6_reg;
    assign compare.cmp_b         = cb6_reg;
    assign compare.cmp_c         = cc6_reg;
    assign compare.sector        = side6_reg.sector;
    assign compare.overmodulated = side6_reg.overmodulated;

endmodule

### design/svpc_divider.sv
module svpc_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [svpc_pkg::NUM_W-1:0]    num_m,
    input  logic [svpc_pkg::NUM_W-1:0]    num_n,
    input  logic [svpc_pkg::DEN_W-1:0]    den,
    input  svpc_pkg::side_t               side_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [svpc_pkg::Q_W-1:0]      quo_m,
    output logic [svpc_pkg::Q_W-1:0]      quo_n,
    output svpc_pkg::side_t               side_out
);

    localparam int unsigned DW = svpc_pkg::DEN_W;
    localparam int unsigned QW = svpc_pkg::Q_W;
    localparam int unsigned NS = svpc_pkg::DIV_STAGES;

    // The partial remainder always stays below the divisor, so one restoring
    // step needs a compare and subtract one bit wider than the divisor.
    function automatic logic [DW+QW-1:0] div_step(
        input logic [DW-1:0] r_in,
        input logic [QW-1:0] l_in,
        input logic [DW-1:0] d
    );
        logic [DW:0]   trial;
        logic [DW-1:0] r;
        logic [QW-1:0] l;
        r = r_in;
        l = l_in;
        for (int j = 0; j < svpc_pkg::BITS_PER_STAGE; j++)
        begin
            trial = {r, l[QW-1]};
            l = {l[QW-2:0], 1'b0};
            if (trial >= {1'b0, d})
            begin
                trial = trial - {1'b0, d};
                l[0] = 1'b1;
            end
            r = trial[DW-1:0];
        end
        return {r, l};
    endfunction

    logic [NS-1:0]          vld_reg;
    logic [DW-1:0]          rm_reg   [NS];
    logic [DW-1:0]          rn_reg   [NS];
    logic [QW-1:0]          lm_reg   [NS];
    logic [QW-1:0]          ln_reg   [NS];
    logic [DW-1:0]          den_reg  [NS];
    svpc_pkg::side_t        side_reg [NS];

    logic [NS-1:0]          vld_src;
    logic [DW-1:0]          rm_src   [NS];
    logic [DW-1:0]          rn_src   [NS];
    logic [QW-1:0]          lm_src   [NS];
    logic [QW-1:0]          ln_src   [NS];
    logic [DW-1:0]          den_src  [NS];
    svpc_pkg::side_t        side_src [NS];

    logic [DW-1:0]          rm_next  [NS];
    logic [DW-1:0]          rn_next  [NS];
    logic [QW-1:0]          lm_next  [NS];
    logic [QW-1:0]          ln_next  [NS];

    logic [NS:0]            adv;

    always_comb
    begin
        adv[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign in_ready = adv[0];

    always_comb
    begin
        vld_src[0]  = in_valid;
        rm_src[0]   = {{(DW - (svpc_pkg::NUM_W - QW)){1'b0}}, num_m[svpc_pkg::NUM_W-1:QW]};
        rn_src[0]   = {{(DW - (svpc_pkg::NUM_W - QW)){1'b0}}, num_n[svpc_pkg::NUM_W-1:QW]};
        lm_src[0]   = num_m[QW-1:0];
        ln_src[0]   = num_n[QW-1:0];
        den_src[0]  = den;
        side_src[0] = side_in;
        for (int k = 1; k < NS; k++)
        begin
            vld_src[k]  = vld_reg[k-1];
            rm_src[k]   = rm_reg[k-1];
            rn_src[k]   = rn_reg[k-1];
            lm_src[k]   = lm_reg[k-1];
            ln_src[k]   = ln_reg[k-1];
            den_src[k]  = den_reg[k-1];
            side_src[k] = side_reg[k-1];
        end
        for (int k = 0; k < NS; k++)
        begin
            {rm_next[k], lm_next[k]} = div_step(rm_src[k], lm_src[k], den_src[k]);
            {rn_next[k], ln_next[k]} = div_step(rn_src[k], ln_src[k], den_src[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_src[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (adv[k] && vld_src[k])
            begin
                rm_reg[k]   <= rm_next[k];
                rn_reg[k]   <= rn_next[k];
                lm_reg[k]   <= lm_next[k];
                ln_reg[k]   <= ln_next[k];
                den_reg[k]  <= den_src[k];
                side_reg[k] <= side_src[k];
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign quo_m     = lm_reg[NS-1];
    assign quo_n     = ln_reg[NS-1];
    assign side_out  = side_reg[NS-1];

endmodule

### design/svpc_checker.sv
module svpc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [svpc_pkg::DATA_W-1:0]   cmp_a,
    input logic [svpc_pkg::DATA_W-1:0]   cmp_b,
    input logic [svpc_pkg::DATA_W-1:0]   cmp_c,
    input logic [svpc_pkg::SECTOR_W-1:0] sector,
    input logic                          overmodulated
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cmp_a) && $stable(cmp_b)
            && $stable(cmp_c) && $stable(sector) && $stable(overmodulated))
        else $error("compare request changed while stalled");

    a_no_bad_sector: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sector != svpc_pkg::SEC_BAD)
        else $error("impossible sector code on the compare channel");

    a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sector == svpc_pkg::SEC_ZERO |->
            cmp_a == cmp_b && cmp_b == cmp_c && !overmodulated)
        else $error("zero vector did not give equal compares");

    a_sector3_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sector == svpc_pkg::SEC_3 |-> cmp_a <= cmp_b && cmp_b <= cmp_c)
        else $error("phase order wrong in sector three");

endmodule

bind space_vector_pwm_compare svpc_checker u_svpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (compare.valid),
    .out_ready     (compare.ready),
    .cmp_a         (compare.cmp_a),
    .cmp_b         (compare.cmp_b),
    .cmp_c         (compare.cmp_c),
    .sector        (compare.sector),
    .overmodulated (compare.overmodulated)
);
